### hdl/planar_pose_composer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the planar pose composer
// Concurrent checks that vanish when the design is synthesised.
// ---------------------------------------------------------------------------
`ifndef PLANAR_POSE_COMPOSER_MACROS_SVH
`define PLANAR_POSE_COMPOSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("planar_pose_composer: check failed");

// Next-cycle implication, checked outside reset.
`define PPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("planar_pose_composer: check failed");

`else

`define PPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/ppc_pkg.sv
// ---------------------------------------------------------------------------
// Planar pose composer package
// Widths, the CORDIC gain and arctangent table, and the datapath record
// that travels along the rotator chain.
// ---------------------------------------------------------------------------
package ppc_pkg;

  // Field widths of the request and the result.
  localparam int unsigned DataW  = 32;
  localparam int unsigned AngleW = 16;

  // Default number of rotator cells.
  localparam int unsigned CordicIterations = 16;

  // Rotator datapath: 48 bits of pre-scaled value plus headroom for the
  // CORDIC growth of about 1.65.
  localparam int unsigned CordicXW = 50;
  localparam int unsigned ZW       = 32;
  // Width after dropping the 16 guard bits.
  localparam int unsigned RndW     = CordicXW - 16;

  // CORDIC gain 0.60725 in Q0.32, held as a positive signed operand.
  localparam logic signed [32:0] KGainS = 33'sh0_9B74_EDA8;

  // Half of the 16 guard bits, for round half up.
  localparam int unsigned RoundHalf = 32768;

  // atan(2^-i) in units of 2^-32 of a turn.
  localparam logic [31:0] AtanTurn [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  // One slot of the rotator chain.
  typedef struct packed {
    logic                       valid;
    logic signed [CordicXW-1:0] x;
    logic signed [CordicXW-1:0] y;
    logic signed [ZW-1:0]       z;
  } cordic_t;

endpackage

### hdl/ppc_cell.sv
// ---------------------------------------------------------------------------
// Rotator cell
// One CORDIC micro-rotation with a fixed shift, registered, passing its
// result to the next cell every cycle.
// ---------------------------------------------------------------------------
module ppc_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ppc_pkg::cordic_t cell_i,
  output ppc_pkg::cordic_t cell_o
);

  localparam logic [4:0]                  AtanIdx = 5'(Shift);
  localparam logic signed [ppc_pkg::ZW-1:0] Atan  = signed'(ppc_pkg::AtanTurn[AtanIdx]);

  logic                                valid_q;
  logic signed [ppc_pkg::CordicXW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ppc_pkg::ZW-1:0]       z_q, z_d;
  logic signed [ppc_pkg::CordicXW-1:0] x_sh, y_sh;

  // Micro-rotation towards zero residual angle.
  always_comb begin
    x_sh = cell_i.x >>> Shift;
    y_sh = cell_i.y >>> Shift;
    if (!cell_i.z[ppc_pkg::ZW-1]) begin
      x_d = cell_i.x - y_sh;
      y_d = cell_i.y + x_sh;
      z_d = cell_i.z - Atan;
    end else begin
      x_d = cell_i.x + y_sh;
      y_d = cell_i.y - x_sh;
      z_d = cell_i.z + Atan;
    end
  end

  // The valid flag is control; the payload follows without reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.x     = x_q;
  assign cell_o.y     = y_q;
  assign cell_o.z     = z_q;

endmodule

### hdl/ppc_prescale.sv
// ---------------------------------------------------------------------------
// Rotator front end
// Scales the translation by the CORDIC gain on one shared multiplier and
// folds the heading into the right half plane before the cell chain.
// ---------------------------------------------------------------------------
module ppc_prescale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ppc_pkg::DataW-1:0]  delta_x_i,
  input  logic signed [ppc_pkg::DataW-1:0]  delta_y_i,
  input  logic        [ppc_pkg::AngleW-1:0] heading_i,
  output ppc_pkg::cordic_t                  head_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SMulX = 2'd1;
  localparam logic [1:0] SMulY = 2'd2;
  localparam logic [1:0] SFold = 2'd3;

  localparam int unsigned ProdW = 2 * ppc_pkg::DataW;
  localparam int unsigned ScalW = ProdW - 16;

  logic [1:0] state_q, state_d;

  logic signed [ppc_pkg::DataW-1:0]    dx_q, dy_q, mul_op;
  logic                                fold_q;
  logic signed [ppc_pkg::ZW-1:0]       z_q;
  logic signed [ProdW:0]               mul_full;
  logic signed [ProdW-1:0]             prod_q;
  logic signed [ScalW-1:0]             x0_q;
  logic signed [ppc_pkg::CordicXW-1:0] x0_ext, y0_ext;
  logic                                valid_q;
  logic signed [ppc_pkg::CordicXW-1:0] x_q, y_q;
  logic signed [ppc_pkg::ZW-1:0]       zo_q;

  // Sequencer: x product, then y product, then fold into the chain.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) state_d = SMulX;
      end
      SMulX: state_d = SMulY;
      SMulY: state_d = SFold;
      SFold: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == SFold);
    end
  end

  // Shared gain multiplier; the product drops 16 bits to leave guard bits.
  assign mul_op   = (state_q == SMulX) ? dx_q : dy_q;
  assign mul_full = mul_op * ppc_pkg::KGainS;
  assign x0_ext   = ppc_pkg::CordicXW'(x0_q);
  assign y0_ext   = ppc_pkg::CordicXW'(signed'(prod_q[ProdW-1:16]));

  // Request capture. Headings in the second and third quadrant are turned
  // by half a turn, which negates the vector and flips the top angle bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q   <= delta_x_i;
      dy_q   <= delta_y_i;
      fold_q <= heading_i[ppc_pkg::AngleW-1] ^ heading_i[ppc_pkg::AngleW-2];
      z_q    <= signed'({heading_i[ppc_pkg::AngleW-2], heading_i[ppc_pkg::AngleW-2:0],
                         16'h0000});
    end
    prod_q <= mul_full[ProdW-1:0];
    if (state_q == SMulY) begin
      x0_q <= prod_q[ProdW-1:16];
    end
    if (state_q == SFold) begin
      x_q  <= fold_q ? -x0_ext : x0_ext;
      y_q  <= fold_q ? -y0_ext : y0_ext;
      zo_q <= z_q;
    end
  end

  assign head_o.valid = valid_q;
  assign head_o.x     = x_q;
  assign head_o.y     = y_q;
  assign head_o.z     = zo_q;

endmodule

### hdl/ppc_accum.sv
// ---------------------------------------------------------------------------
// Pose accumulator
// Rounds the rotated translation, adds it to the position with saturation,
// advances the heading and holds the pose as the result register.
// ---------------------------------------------------------------------------
module ppc_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic        [ppc_pkg::AngleW-1:0] delta_angle_i,
  input  ppc_pkg::cordic_t                  tail_i,
  input  logic                              m_ready_i,
  output logic                              m_valid_o,
  output logic                              done_o,
  output logic signed [ppc_pkg::DataW-1:0]  pose_x_o,
  output logic signed [ppc_pkg::DataW-1:0]  pose_y_o,
  output logic        [ppc_pkg::AngleW-1:0] heading_o
);

  localparam int unsigned SumW = ppc_pkg::RndW + 1;
  localparam logic signed [ppc_pkg::DataW-1:0] PosMax = {1'b0, {(ppc_pkg::DataW-1){1'b1}}};
  localparam logic signed [ppc_pkg::DataW-1:0] PosMin = {1'b1, {(ppc_pkg::DataW-1){1'b0}}};

  logic        [ppc_pkg::AngleW-1:0]   da_q, heading_q;
  logic signed [ppc_pkg::DataW-1:0]    pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic signed [ppc_pkg::CordicXW-1:0] xr, yr;
  logic signed [ppc_pkg::RndW-1:0]     rx_q, ry_q;
  logic signed [SumW-1:0]              sum_x, sum_y;
  logic                                pend_q, out_valid_q, load;

  // Round half up while dropping the guard bits.
  assign xr = tail_i.x + ppc_pkg::CordicXW'(ppc_pkg::RoundHalf);
  assign yr = tail_i.y + ppc_pkg::CordicXW'(ppc_pkg::RoundHalf);

  // Saturating position update.
  always_comb begin
    sum_x = SumW'(pos_x_q) + SumW'(rx_q);
    sum_y = SumW'(pos_y_q) + SumW'(ry_q);
    if (sum_x[SumW-1:ppc_pkg::DataW-1] == '0 || sum_x[SumW-1:ppc_pkg::DataW-1] == '1) begin
      pos_x_d = sum_x[ppc_pkg::DataW-1:0];
    end else begin
      pos_x_d = sum_x[SumW-1] ? PosMin : PosMax;
    end
    if (sum_y[SumW-1:ppc_pkg::DataW-1] == '0 || sum_y[SumW-1:ppc_pkg::DataW-1] == '1) begin
      pos_y_d = sum_y[ppc_pkg::DataW-1:0];
    end else begin
      pos_y_d = sum_y[SumW-1] ? PosMin : PosMax;
    end
  end

  // The pose is loaded once the result register is free.
  assign load = pend_q && (!out_valid_q || m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      if (load) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
        pos_x_q     <= pos_x_d;
        pos_y_q     <= pos_y_d;
        heading_q   <= heading_q + da_q;
      end else begin
        if (tail_i.valid) pend_q <= 1'b1;
        if (m_ready_i) out_valid_q <= 1'b0;
      end
    end
  end

  // Request angle and rounded rotation, both held until the load.
  always_ff @(posedge clk_i) begin
    if (start_i) da_q <= delta_angle_i;
    if (tail_i.valid) begin
      rx_q <= xr[ppc_pkg::CordicXW-1:16];
      ry_q <= yr[ppc_pkg::CordicXW-1:16];
    end
  end

  assign m_valid_o = out_valid_q;
  assign done_o    = load;
  assign pose_x_o  = pos_x_q;
  assign pose_y_o  = pos_y_q;
  assign heading_o = heading_q;

endmodule

### hdl/planar_pose_composer.sv
// ---------------------------------------------------------------------------
// Planar pose composer
// Composes relative planar transforms onto a running pose (x, y, heading).
// ---------------------------------------------------------------------------
// Each request carries a relative translation (Q16.16) and a relative
// rotation (binary angle). The translation is turned by the current heading
// in a chain of CORDIC_ITERATIONS rotator cells, added to the position with
// saturation, and the new pose is returned. One request is worked at a time:
// the translation passes the shared gain multiplier (x product, then y
// product), the fold register, each rotator cell in turn, the rounding
// register and the accumulate, whose load into the result register waits
// while that register still holds a pose not yet taken; the next request
// is taken once the new pose is loaded. A finished pose may wait in the output
// register while the next request is already being worked.
// ---------------------------------------------------------------------------
`include "planar_pose_composer_macros.svh"

module planar_pose_composer #(
  parameter int unsigned CORDIC_ITERATIONS = ppc_pkg::CordicIterations
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata_i: delta_x [31:0], delta_y [63:32], delta_angle [79:64]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,
  // m_axis_tdata_o: pose_x [31:0], pose_y [63:32], heading [79:64]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o
);

  localparam int unsigned DW = ppc_pkg::DataW;
  localparam int unsigned AW = ppc_pkg::AngleW;

  logic                    busy_q, accept, done;
  logic [AW-1:0]           heading;
  logic signed [DW-1:0]    pose_x, pose_y;
  ppc_pkg::cordic_t        chain [CORDIC_ITERATIONS+1];
  logic [CORDIC_ITERATIONS:0] chain_valid;

  // Request handshake: one request in flight.
  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  // Gain scaling and quadrant fold.
  ppc_prescale u_prescale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .delta_x_i (signed'(s_axis_tdata_i[DW-1:0])),
    .delta_y_i (signed'(s_axis_tdata_i[2*DW-1:DW])),
    .heading_i (heading),
    .head_o    (chain[0])
  );

  // Row of rotator cells, one micro-rotation each.
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
    ppc_cell #(
      .Shift (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  for (genvar i = 0; i <= CORDIC_ITERATIONS; i++) begin : g_valid
    assign chain_valid[i] = chain[i].valid;
  end

  // Rounding, saturating accumulate and result register.
  ppc_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .delta_angle_i (s_axis_tdata_i[2*DW+AW-1:2*DW]),
    .tail_i        (chain[CORDIC_ITERATIONS]),
    .m_ready_i     (m_axis_tready_i),
    .m_valid_o     (m_axis_tvalid_o),
    .done_o        (done),
    .pose_x_o      (pose_x),
    .pose_y_o      (pose_y),
    .heading_o     (heading)
  );

  assign m_axis_tdata_o = {heading, pose_y, pose_x};

  // Checks on the request bookkeeping and the cell chain.
  `PPC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, busy_q)
  `PPC_ASSERT_IMP(a_single_in_chain, clk_i, rst_ni, 1'b1, $onehot0(chain_valid))
  `PPC_ASSERT_IMP(a_idle_chain_empty, clk_i, rst_ni, !busy_q, chain_valid == '0)
  `PPC_ASSERT_IMP(a_done_when_busy, clk_i, rst_ni, done, busy_q && chain_valid == '0)

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Planar pose composer testbench
// Drives relative transform requests into the composer and checks every
// returned pose against a local fixed-point model of the CORDIC rotation,
// the saturating position update and the wrapping heading.
// ---------------------------------------------------------------------------
module testbench;

  // Rotator depth used by the instance and by the local model.
  localparam int unsigned CORDIC_STEPS = ppc_pkg::CordicIterations;

  // Cycles without any accepted request or result before giving up.
  localparam int unsigned QUIET_LIMIT = 5000;

  // Length of the deliberate output hold-off, and the result it follows.
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned LONG_HOLD_AT     = 300;

  // Final stretch of the run, counted in requests, with no idling.
  localparam int unsigned STEADY_TAIL = 150;

  localparam int unsigned RANDOM_COUNT = 1950;

  // CORDIC gain 0.60725 in Q0.32.
  localparam longint GAIN_Q32 = 64'h0000_0000_9B74_EDA8;

  // atan(2^-i) in units of 2^-32 of a turn.
  localparam logic [31:0] ATAN_STEP [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct packed {
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic [15:0]        delta_angle;
    logic               wait_drain;
  } transform_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        heading;
  } pose_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [79:0] in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [79:0] out_data;

  transform_t transform_q[$];
  pose_t      pose_due_q[$];
  transform_t offered;

  // Running pose as the model sees it.
  logic signed [31:0] track_x       = '0;
  logic signed [31:0] track_y       = '0;
  logic [15:0]        track_heading = '0;

  int unsigned total_requests = 0;
  int unsigned taken_count    = 0;
  int unsigned returned_count = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;

  planar_pose_composer #(
    .CORDIC_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),   // delta_x [31:0], delta_y [63:32], delta_angle [79:64]
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data)   // pose_x [31:0], pose_y [63:32], heading [79:64]
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Clamp a wide sum to the signed 32 bit range.
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Apply one relative transform to the running pose and return the new pose.
  function automatic pose_t compose_pose(input transform_t t);
    logic [31:0] turn;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    pose_t       p;
    turn = {track_heading, 16'h0000};
    x = (longint'(t.delta_x) * GAIN_Q32) >>> 16;
    y = (longint'(t.delta_y) * GAIN_Q32) >>> 16;
    // Fold the second and third quadrants onto the first and fourth.
    if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
      x = -x;
      y = -y;
      turn = turn - 32'h8000_0000;
    end
    z = longint'($signed(turn));
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_STEP[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_STEP[i]);
      end
    end
    // Round half up while dropping the guard bits, then accumulate.
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    track_x       = clamp32(longint'(track_x) + x);
    track_y       = clamp32(longint'(track_y) + y);
    track_heading = track_heading + t.delta_angle;
    p.pose_x  = track_x;
    p.pose_y  = track_y;
    p.heading = track_heading;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("MISMATCH %s: got %08h, expected %08h (result %0d)",
               what, got, want, returned_count);
    error_count++;
  endtask

  task automatic add_transform(input logic [31:0] dx, input logic [31:0] dy,
                               input logic [15:0] da, input bit drain);
    transform_t t;
    t.delta_x     = dx;
    t.delta_y     = dy;
    t.delta_angle = da;
    t.wait_drain  = drain;
    transform_q.push_back(t);
  endtask

  // Request driver: records each accepted request and offers the next one.
  always @(posedge clk_i) begin
    bit         offering;
    bit         next_valid;
    int unsigned idle_mode;
    if (rst_ni) begin
      offering   = in_valid;
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        pose_due_q.push_back(compose_pose(offered));
        taken_count++;
        offering   = 1'b0;
        next_valid = 1'b0;
      end
      if (!offering) begin
        idle_mode = (taken_count >> 7) % 3;
        if (send_gap > 0) begin
          send_gap--;
        end else if (transform_q.size() > 0) begin
          if (transform_q[0].wait_drain && pose_due_q.size() != 0) begin
            // Hold back until every outstanding pose has returned.
          end else if (transform_q.size() > STEADY_TAIL && idle_mode != 0 &&
                       $urandom_range(0, (idle_mode == 1) ? 7 : 2) == 0) begin
            send_gap = $urandom_range(1, 11);
          end else begin
            offered    = transform_q.pop_front();
            next_valid = 1'b1;
            in_data   <= {offered.delta_angle, offered.delta_y, offered.delta_x};
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Result monitor: checks each returned pose and paces the ready line.
  always @(posedge clk_i) begin
    pose_t       got;
    pose_t       want;
    bit          next_ready;
    int unsigned stall_mode;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got.pose_x  = out_data[31:0];
        got.pose_y  = out_data[63:32];
        got.heading = out_data[79:64];
        if (pose_due_q.size() == 0) begin
          report_mismatch("unexpected result", got.pose_x, 32'h0);
        end else begin
          want = pose_due_q.pop_front();
          if (got.pose_x !== want.pose_x)
            report_mismatch("pose_x", got.pose_x, want.pose_x);
          if (got.pose_y !== want.pose_y)
            report_mismatch("pose_y", got.pose_y, want.pose_y);
          if (got.heading !== want.heading)
            report_mismatch("heading", {16'h0, got.heading}, {16'h0, want.heading});
        end
        returned_count++;
      end
      stall_mode = (returned_count / 100) % 3;
      next_ready = 1'b1;
      if (long_hold_left > 0) begin
        long_hold_left--;
        next_ready = 1'b0;
      end else if (!long_hold_done && returned_count == LONG_HOLD_AT) begin
        // Long hold-off so that the block fills up and stalls its input.
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD_CYCLES;
        next_ready     = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        next_ready = 1'b0;
      end else if (returned_count + STEADY_TAIL < total_requests && stall_mode != 0 &&
                   $urandom_range(0, (stall_mode == 1) ? 7 : 2) == 0) begin
        recv_gap   = $urandom_range(1, 11);
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int          kind;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [15:0] da;

    // Directed part: extremes, quadrant folds, saturation and heading wrap.
    add_transform(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0);
    add_transform(32'h0000_0001, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    add_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    add_transform(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h3FFF, 1'b0);
    add_transform(32'h7FFF_FFFF, 32'h0000_0000, 16'h0001, 1'b0);
    add_transform(32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0);
    add_transform(32'h8000_0000, 32'h8000_0000, 16'h4000, 1'b0);
    add_transform(32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0);
    add_transform(32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0);
    add_transform(32'h0001_0000, 32'h0000_0000, 16'h3FFF, 1'b0);
    add_transform(32'h0001_0000, 32'h0001_0000, 16'h8000, 1'b0);
    add_transform(32'h0001_0000, 32'h0001_0000, 16'h0001, 1'b0);
    add_transform(32'hFFFF_0000, 32'h0002_8000, 16'h3FFF, 1'b0);
    add_transform(32'h0000_8000, 32'hFFFF_8000, 16'h4000, 1'b0);
    add_transform(32'h1234_5678, 32'hEDCB_A988, 16'h7FFF, 1'b0);
    add_transform(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0);
    add_transform(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    add_transform(32'h0000_0001, 32'h0000_0001, 16'h0001, 1'b0);
    add_transform(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    add_transform(32'h0003_0000, 32'hFFFD_0000, 16'h0000, 1'b0);

    // Random part: mostly odometry-sized steps, with some large and raw values.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      kind = $urandom_range(0, 7);
      if (kind < 5) begin
        dx = int'($urandom_range(0, 524288)) - 262144;
        dy = int'($urandom_range(0, 524288)) - 262144;
      end else if (kind < 7) begin
        dx = int'($urandom_range(0, 33554432)) - 16777216;
        dy = int'($urandom_range(0, 33554432)) - 16777216;
      end else begin
        dx = $urandom;
        dy = $urandom;
      end
      if ($urandom_range(0, 1) == 0)
        da = 16'(int'($urandom_range(0, 1024)) - 512);
      else
        da = 16'($urandom);
      add_transform(dx, dy, da, n == 1000 || n == 1500);
    end
    total_requests = transform_q.size();

    // Reset held at the start of the run, then released.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (transform_q.size() != 0 || in_valid) @(posedge clk_i);
    while (pose_due_q.size() != 0) @(posedge clk_i);
    repeat (CORDIC_STEPS + 20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/ppc_pkg.sv
hdl/ppc_cell.sv
hdl/ppc_prescale.sv
hdl/ppc_accum.sv
hdl/planar_pose_composer.sv
verif/testbench.sv
